FILE: rtl/core/qte_pkg.sv
package qte_pkg;

    // field and datapath widths
    localparam int Q_W        = 16;   // quaternion component, Q14
    localparam int PROD_W     = 32;   // 16x16 signed product, Q28
    localparam int SUM_W      = 34;   // 2*(a*b +- c*d), Q28
    localparam int CRD_W      = 36;   // CORDIC x/y working width
    localparam int ANG_W      = 33;   // CORDIC angle, Q29
    localparam int Q13_W      = 17;   // rounded angle before final truncation
    localparam int OUT_XZ_W   = 16;
    localparam int OUT_Y_W    = 15;
    localparam int MAG_W      = 28;   // |sin(pitch)| below one, Q28
    localparam int SP_W       = MAG_W + 1;
    localparam int REM_W      = 2 * MAG_W + 1;   // 1 - s^2, Q56
    localparam int SQRT_W     = REM_W + 1;
    localparam int ROOT_W     = MAG_W + 1;
    localparam int SQRT_STEPS = MAG_W + 1;       // one result bit per stage

    localparam int CORDIC_STAGES = 16;

    // pipeline depth bookkeeping (stage 1 is loaded at the accepting edge)
    localparam int FRONT_DEPTH = 2;
    localparam int PREP_DEPTH  = 3;
    localparam int CRD_DEPTH   = CORDIC_STAGES + 1;
    localparam int SP_DLY      = PREP_DEPTH - 1 + SQRT_STEPS;
    localparam int FLAG_DLY    = SP_DLY + CRD_DEPTH;
    localparam int XZ_DLY      = PREP_DEPTH + SQRT_STEPS;
    localparam int PIPE_DEPTH  = FRONT_DEPTH + PREP_DEPTH + SQRT_STEPS + CRD_DEPTH + 1;

    localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(268435456);
    localparam logic signed [ANG_W-1:0] PI_Q29      = ANG_W'(1686629713);
    localparam logic signed [Q13_W-1:0] PI_Q13      = Q13_W'(25736);
    localparam logic signed [Q13_W-1:0] HALF_PI_Q13 = Q13_W'(12868);
    localparam logic [REM_W-1:0]        REM_ONE     = REM_W'(1) << (2 * MAG_W);
    localparam logic signed [ANG_W:0]   Q13_RND     = (ANG_W + 1)'(32768);

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] cx;
        logic signed [SUM_W-1:0] sz;
        logic signed [SUM_W-1:0] cz;
        logic signed [SUM_W-1:0] sp;
    } t_sums;

    typedef struct packed {
        logic hi;     // argument at or above +1
        logic lo;     // argument at or below -1
        logic clip;   // argument strictly beyond magnitude one
    } t_pitch_flags;

    typedef struct packed {
        logic                       clip;
        logic signed [OUT_XZ_W-1:0] az;
        logic signed [OUT_Y_W-1:0]  ay;
        logic signed [OUT_XZ_W-1:0] ax;
    } t_result;

    // atan(2^-i), Q29
    function automatic logic signed [ANG_W-1:0] atan_q29(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = ANG_W'(421657428);
            5'd1:    v = ANG_W'(248918915);
            5'd2:    v = ANG_W'(131521918);
            5'd3:    v = ANG_W'(66762579);
            5'd4:    v = ANG_W'(33510843);
            5'd5:    v = ANG_W'(16771758);
            5'd6:    v = ANG_W'(8387925);
            5'd7:    v = ANG_W'(4194219);
            5'd8:    v = ANG_W'(2097141);
            5'd9:    v = ANG_W'(1048575);
            5'd10:   v = ANG_W'(524288);
            5'd11:   v = ANG_W'(262144);
            5'd12:   v = ANG_W'(131072);
            5'd13:   v = ANG_W'(65536);
            5'd14:   v = ANG_W'(32768);
            5'd15:   v = ANG_W'(16384);
            5'd16:   v = ANG_W'(8192);
            5'd17:   v = ANG_W'(4096);
            5'd18:   v = ANG_W'(2048);
            5'd19:   v = ANG_W'(1024);
            5'd20:   v = ANG_W'(512);
            5'd21:   v = ANG_W'(256);
            5'd22:   v = ANG_W'(128);
            5'd23:   v = ANG_W'(64);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q29 -> Q13, round half up, then clamp to +-lim
    function automatic logic signed [Q13_W-1:0] q13_sat(
        input logic signed [ANG_W-1:0] z,
        input logic signed [Q13_W-1:0] lim
    );
        logic signed [ANG_W:0]    t;
        logic signed [ANG_W-16:0] r;
        logic signed [Q13_W-1:0]  res;
        t = {z[ANG_W-1], z} + Q13_RND;
        r = t[ANG_W:16];
        if (r > lim) begin
            res = lim;
        end else if (r < -lim) begin
            res = -lim;
        end else begin
            res = r[Q13_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/qte_front.sv
module qte_front
    import qte_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [Q_W-1:0] i_w,
    input  logic signed [Q_W-1:0] i_x,
    input  logic signed [Q_W-1:0] i_y,
    input  logic signed [Q_W-1:0] i_z,
    output t_sums                 o_sums
);

    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    t_sums r_sums;
    t_sums n_sums;

    // stage 1: all products in parallel
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
        end
    end

    // stage 2: doubled sums, exact in Q28
    always_comb begin
        n_sums.sx = (SUM_W'(r_wx) + SUM_W'(r_yz)) <<< 1;
        n_sums.cx = ONE_Q28 - ((SUM_W'(r_xx) + SUM_W'(r_yy)) <<< 1);
        n_sums.sz = (SUM_W'(r_wz) + SUM_W'(r_xy)) <<< 1;
        n_sums.cz = ONE_Q28 - ((SUM_W'(r_yy) + SUM_W'(r_zz)) <<< 1);
        n_sums.sp = (SUM_W'(r_wy) - SUM_W'(r_zx)) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sums <= n_sums;
        end
    end

    assign o_sums = r_sums;

endmodule

FILE: rtl/core/qte_sqrt.sv
module qte_sqrt
    import qte_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [REM_W-1:0]  i_rem,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQRT_W-1:0] r_v [0:SQRT_STEPS-1];
    logic [SQRT_W-1:0] r_r [0:SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        localparam logic [SQRT_W-1:0] BIT_K = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));

        logic [SQRT_W-1:0] v_in, r_in, trial, n_v, n_r;

        if (k == 0) begin : g_first
            assign v_in = SQRT_W'(i_rem);
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign r_in = r_r[k-1];
        end

        // restoring step: try the next root bit
        always_comb begin
            trial = r_in + BIT_K;
            if (v_in >= trial) begin
                n_v = v_in - trial;
                n_r = (r_in >> 1) + BIT_K;
            end else begin
                n_v = v_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[k] <= n_v;
                r_r[k] <= n_r;
            end
        end
    end

    assign o_root = r_r[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

FILE: rtl/core/qte_cordic.sv
module qte_cordic
    import qte_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [SUM_W-1:0] i_y,
    input  logic signed [SUM_W-1:0] i_x,
    output logic signed [ANG_W-1:0] o_angle
);

    logic signed [CRD_W-1:0] r_x [0:CORDIC_STAGES];
    logic signed [CRD_W-1:0] r_y [0:CORDIC_STAGES];
    logic signed [ANG_W-1:0] r_z [0:CORDIC_STAGES];
    logic                    r_zero [0:CORDIC_STAGES];

    logic signed [CRD_W-1:0] xe, ye;

    assign xe = CRD_W'(i_x);
    assign ye = CRD_W'(i_y);

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -xe;
                r_y[0] <= -ye;
                r_z[0] <= (i_y >= 0) ? PI_Q29 : -PI_Q29;
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [CRD_W-1:0] xs, ys, n_x, n_y;
        logic signed [ANG_W-1:0] n_z;

        always_comb begin
            xs = r_x[i] >>> i;
            ys = r_y[i] >>> i;
            if (r_y[i] >= 0) begin
                n_x = r_x[i] + ys;
                n_y = r_y[i] - xs;
                n_z = r_z[i] + atan_q29(5'(i));
            end else begin
                n_x = r_x[i] - ys;
                n_y = r_y[i] + xs;
                n_z = r_z[i] - atan_q29(5'(i));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_angle = r_zero[CORDIC_STAGES] ? '0 : r_z[CORDIC_STAGES];

endmodule

FILE: rtl/core/quaternion_to_euler_angles_core.sv
// Path: an accepted request passes the product, sum, pitch-prep, square-root, CORDIC and
//   rounding registers before o_m_axis_tvalid rises, when the output register is free.
// Throughput: one request per cycle while the skid entry is empty; the depth comes from
//   the 29-stage square root feeding the pitch CORDIC, with roll and yaw delay-matched to it.
// Reset: synchronous, active-low i_rst_n clears the pipeline, output and skid valid bits.
module quaternion_to_euler_angles_core
    import qte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // quat_w [15:0], quat_x [31:16], quat_y [47:32],
                                          // quat_z [63:48]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // angle_about_x [15:0], angle_about_y [30:16],
                                          // angle_about_z [46:31], zero [47]
    output logic        o_m_axis_tuser    // pitch_clipped [0]
);

    // ------------------------------------------------------------------
    // Global advance. The whole pipeline moves together; it only halts
    // when both the output register and the skid register hold results.
    // ------------------------------------------------------------------
    logic en;
    logic r_skid_v;
    logic r_out_v;

    assign en              = !r_skid_v;
    assign o_s_axis_tready = en;

    // Valid bits, one per pipeline stage.
    logic r_vld [1:PIPE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-2: products and the five doubled sums.
    // ------------------------------------------------------------------
    t_sums w_sums;

    qte_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_w    (i_s_axis_tdata[15:0]),
        .i_x    (i_s_axis_tdata[31:16]),
        .i_y    (i_s_axis_tdata[47:32]),
        .i_z    (i_s_axis_tdata[63:48]),
        .o_sums (w_sums)
    );

    // ------------------------------------------------------------------
    // Roll and yaw: CORDIC straight off the sums, round, then delay
    // to meet the pitch path at the last stage.
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0]    w_ang_x, w_ang_z;
    logic signed [Q13_W-1:0]    w_ax17, w_az17;
    logic signed [OUT_XZ_W-1:0] r_ax_q, r_az_q;
    logic signed [OUT_XZ_W-1:0] r_ax_dly [0:XZ_DLY-1];
    logic signed [OUT_XZ_W-1:0] r_az_dly [0:XZ_DLY-1];

    qte_cordic u_crd_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (w_sums.sx),
        .i_x     (w_sums.cx),
        .o_angle (w_ang_x)
    );

    qte_cordic u_crd_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (w_sums.sz),
        .i_x     (w_sums.cz),
        .o_angle (w_ang_z)
    );

    assign w_ax17 = q13_sat(w_ang_x, PI_Q13);
    assign w_az17 = q13_sat(w_ang_z, PI_Q13);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax_q      <= w_ax17[OUT_XZ_W-1:0];
            r_az_q      <= w_az17[OUT_XZ_W-1:0];
            r_ax_dly[0] <= r_ax_q;
            r_az_dly[0] <= r_az_q;
            for (int k = 1; k < XZ_DLY; k++) begin
                r_ax_dly[k] <= r_ax_dly[k-1];
                r_az_dly[k] <= r_az_dly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pitch: asin(s) = atan2(s, sqrt(1 - s^2)).
    // Stage 3 classifies s against +-1, stage 4 squares |s|, stage 5
    // forms 1 - s^2 in Q56. Out-of-range arguments push zeros through
    // and are overridden at the end.
    // ------------------------------------------------------------------
    t_pitch_flags            n_p3_flags, r_p3_flags;
    logic signed [SUM_W-1:0] sp_abs;
    logic                    sp_in_rng;
    logic signed [SP_W-1:0]  r_p3_sp;
    logic [MAG_W-1:0]        r_p3_mag;
    logic [2*MAG_W-1:0]      r_p4_sq;
    logic [REM_W-1:0]        r_p5_rem;

    always_comb begin
        n_p3_flags.hi   = w_sums.sp >= ONE_Q28;
        n_p3_flags.lo   = w_sums.sp <= -ONE_Q28;
        n_p3_flags.clip = (w_sums.sp > ONE_Q28) || (w_sums.sp < -ONE_Q28);
        sp_in_rng       = !n_p3_flags.hi && !n_p3_flags.lo;
        sp_abs          = (w_sums.sp < 0) ? -w_sums.sp : w_sums.sp;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_flags <= n_p3_flags;
            r_p3_sp    <= sp_in_rng ? w_sums.sp[SP_W-1:0] : '0;
            r_p3_mag   <= sp_in_rng ? sp_abs[MAG_W-1:0] : '0;
            r_p4_sq    <= r_p3_mag * r_p3_mag;
            r_p5_rem   <= REM_ONE - REM_W'(r_p4_sq);
        end
    end

    // Hold s beside the square root, and the range flags beside the square root and CORDIC.
    logic signed [SP_W-1:0] r_sp_dly [0:SP_DLY-1];
    t_pitch_flags           r_fl_dly [0:FLAG_DLY-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp_dly[0] <= r_p3_sp;
            for (int k = 1; k < SP_DLY; k++) begin
                r_sp_dly[k] <= r_sp_dly[k-1];
            end
            r_fl_dly[0] <= r_p3_flags;
            for (int k = 1; k < FLAG_DLY; k++) begin
                r_fl_dly[k] <= r_fl_dly[k-1];
            end
        end
    end

    logic [ROOT_W-1:0]       w_root;
    logic signed [SUM_W-1:0] w_asin_y, w_asin_x;
    logic signed [ANG_W-1:0] w_ang_y;

    qte_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rem  (r_p5_rem),
        .o_root (w_root)
    );

    assign w_asin_y = SUM_W'(r_sp_dly[SP_DLY-1]);
    assign w_asin_x = SUM_W'(w_root);

    qte_cordic u_crd_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (w_asin_y),
        .i_x     (w_asin_x),
        .o_angle (w_ang_y)
    );

    // Last stage: round pitch, or pin it to +-pi/2 at and beyond +-1.
    t_pitch_flags            w_fl;
    logic signed [Q13_W-1:0] n_ay17;
    logic signed [OUT_Y_W-1:0] r_ay_q;
    logic                    r_clip_q;

    assign w_fl = r_fl_dly[FLAG_DLY-1];

    always_comb begin
        if (w_fl.hi) begin
            n_ay17 = HALF_PI_Q13;
        end else if (w_fl.lo) begin
            n_ay17 = -HALF_PI_Q13;
        end else begin
            n_ay17 = q13_sat(w_ang_y, HALF_PI_Q13);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ay_q   <= n_ay17[OUT_Y_W-1:0];
            r_clip_q <= w_fl.clip;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus one skid entry. A result leaving the pipeline
    // goes to the output register when it is free, else into the skid.
    // The skid drains first, so order is kept.
    // ------------------------------------------------------------------
    t_result w_last;
    t_result r_out_d, r_skid_d;
    logic    push, pop;

    always_comb begin
        w_last.ax   = r_ax_dly[XZ_DLY-1];
        w_last.ay   = r_ay_q;
        w_last.az   = r_az_dly[XZ_DLY-1];
        w_last.clip = r_clip_q;
    end

    assign push = en && r_vld[PIPE_DEPTH];
    assign pop  = r_out_v && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || pop) begin
                if (r_skid_v) begin
                    // drain the skid entry first
                    r_out_v  <= 1'b1;
                    r_out_d  <= r_skid_d;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out_v <= push;
                    r_out_d <= w_last;
                end
            end else if (push) begin
                // output stalled: park the new result
                r_skid_v <= 1'b1;
                r_skid_d <= w_last;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {1'b0, r_out_d.az, r_out_d.ay, r_out_d.ax};
    assign o_m_axis_tuser  = r_out_d.clip;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while output register empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !i_m_axis_tready))
        else $error("skid filled without an output stall");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_m_axis_tready) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not moved to output");

    a_clip_pins_pitch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out_d.clip) |->
            (r_out_d.ay == OUT_Y_W'(HALF_PI_Q13) || r_out_d.ay == OUT_Y_W'(-HALF_PI_Q13)))
        else $error("clipped pitch not at +-pi/2");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> (r_out_d.ax <= PI_Q13 && r_out_d.ax >= -PI_Q13
                     && r_out_d.az <= PI_Q13 && r_out_d.az >= -PI_Q13))
        else $error("roll or yaw beyond +-pi");

endmodule
